[rtl/core/heightfield_refraction_shader_macros.svh]
// Assertion helpers used by the checker in hfrs_checker.sv.
`ifndef HEIGHTFIELD_REFRACTION_SHADER_MACROS_SVH
`define HEIGHTFIELD_REFRACTION_SHADER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hfrs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HFRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hfrs assertion failed");

`endif

[rtl/core/hfrs_pkg.sv]
`timescale 1ns / 1ps
package hfrs_pkg;

	localparam int GRID_SHIFT_DEF   = 5;
	localparam int HEIGHT_WIDTH_DEF = 16;

	localparam int POS_W       = 5;
	localparam int SAMPLE_W    = 16;
	localparam int TEXEL_W     = 16;
	localparam int SHIFT_W     = 4;
	localparam int WIND_W      = 5;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 5;

	typedef enum logic [1:0] {
		ACT_WRITE_HEIGHT = 2'd0,
		ACT_WRITE_TEXEL  = 2'd1,
		ACT_SHADE        = 2'd2
	} action_t;

	localparam logic [CFG_INDEX_W-1:0] REG_SHADE_SHIFT   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REFRACT_SHIFT = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WIND_COL      = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WIND_ROW      = 8'd3;

	localparam logic [SHIFT_W-1:0] SHADE_SHIFT_RST   = 4'd2;
	localparam logic [SHIFT_W-1:0] REFRACT_SHIFT_RST = 4'd3;
	localparam logic [WIND_W-1:0]  WIND_RST          = 5'd0;

	typedef struct packed {
		logic [SHIFT_W-1:0] shade_shift;
		logic [SHIFT_W-1:0] refract_shift;
		logic [WIND_W-1:0]  wind_col;
		logic [WIND_W-1:0]  wind_row;
	} cfg_t;

	typedef struct packed {
		action_t                    action;
		logic [POS_W-1:0]           pos_x;
		logic [POS_W-1:0]           pos_y;
		logic signed [SAMPLE_W-1:0] height_value;
		logic [TEXEL_W-1:0]         texel_value;
	} item_t;

	localparam logic [TEXEL_W-1:0] RED_MASK = 16'h0F00;
	localparam logic [TEXEL_W-1:0] GRN_MASK = 16'h00F0;
	localparam logic [TEXEL_W-1:0] BLU_MASK = 16'h000F;
	localparam logic [TEXEL_W-1:0] ALPHA    = 16'hF000;

	localparam int RED_POS   = 8;
	localparam int GRN_POS   = 4;
	localparam int RED_MAX   = 32'h0FFF;
	localparam int RED_MIN   = 32'h0100;
	localparam int GRN_LIMIT = 32'h00FE;
	localparam int GRN_MAX   = 32'h00FF;
	localparam int GRN_MIN   = 32'h0010;
	localparam int BLU_LIMIT = 32'h000E;
	localparam int BLU_MAX   = 32'h000F;

	localparam int SHADE_TRAP = 6;
	localparam int SHADE_SUB  = 4;
	// beyond this magnitude every channel result is already saturated
	localparam int SHADE_SAT  = 16;
	localparam int SHADE_W    = 6;

endpackage

[rtl/core/hfrs_ram.sv]
`timescale 1ns / 1ps
module hfrs_ram #(
	parameter int WIDTH = hfrs_pkg::TEXEL_W,
	parameter int DEPTH = 1 << (2 * hfrs_pkg::GRID_SHIFT_DEF),
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/hfrs_cfg.sv]
`timescale 1ns / 1ps
module hfrs_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hfrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [hfrs_pkg::CFG_DATA_W-1:0]    cfg_data,
	output hfrs_pkg::cfg_t                     cfg
);

	hfrs_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shade_shift   <= hfrs_pkg::SHADE_SHIFT_RST;
			cfg_q.refract_shift <= hfrs_pkg::REFRACT_SHIFT_RST;
			cfg_q.wind_col      <= hfrs_pkg::WIND_RST;
			cfg_q.wind_row      <= hfrs_pkg::WIND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hfrs_pkg::REG_SHADE_SHIFT: begin
					cfg_q.shade_shift <= cfg_data[hfrs_pkg::SHIFT_W-1:0];
				end
				hfrs_pkg::REG_REFRACT_SHIFT: begin
					cfg_q.refract_shift <= cfg_data[hfrs_pkg::SHIFT_W-1:0];
				end
				hfrs_pkg::REG_WIND_COL: begin
					cfg_q.wind_col <= cfg_data[hfrs_pkg::WIND_W-1:0];
				end
				hfrs_pkg::REG_WIND_ROW: begin
					cfg_q.wind_row <= cfg_data[hfrs_pkg::WIND_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/hfrs_height.sv]
`timescale 1ns / 1ps
module hfrs_height #(
	parameter int GRID_SHIFT   = hfrs_pkg::GRID_SHIFT_DEF,
	parameter int HEIGHT_WIDTH = hfrs_pkg::HEIGHT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  hfrs_pkg::item_t              in_item,
	input  hfrs_pkg::cfg_t               cfg,
	output logic                         valid_s2,
	output hfrs_pkg::item_t              item_s2,
	output logic signed [HEIGHT_WIDTH:0] dx_s2,
	output logic signed [HEIGHT_WIDTH:0] dy_s2
);

	localparam int GW    = GRID_SHIFT;
	localparam int AW    = 2 * GW;
	localparam int DEPTH = 1 << AW;
	localparam int HW    = HEIGHT_WIDTH;

	logic [GW-1:0]   x_g, y_g, gx, gy, gx_n, gy_n;
	logic [AW-1:0]   waddr, addr_c, addr_d, addr_r;
	logic            we;
	logic [HW-1:0]   wdata, h_c, h_d, h_r;
	logic            valid_s1;
	hfrs_pkg::item_t item_s1;

	always_comb begin
		x_g    = GW'(in_item.pos_x);
		y_g    = GW'(in_item.pos_y);
		gx     = x_g + GW'(cfg.wind_col);
		gy     = y_g + GW'(cfg.wind_row);
		gx_n   = gx + GW'(1);
		gy_n   = gy + GW'(1);
		addr_c = {gy, gx};
		addr_d = {gy_n, gx};
		addr_r = {gy, gx_n};
		waddr  = {y_g, x_g};
		wdata  = HW'($signed(in_item.height_value));
		we     = en && in_valid && (in_item.action == hfrs_pkg::ACT_WRITE_HEIGHT);
	end

	hfrs_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_ram_c (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(en), .raddr(addr_c), .rdata(h_c)
	);

	hfrs_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_ram_d (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(en), .raddr(addr_d), .rdata(h_d)
	);

	hfrs_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_ram_r (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(en), .raddr(addr_r), .rdata(h_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			item_s2 <= item_s1;
			dy_s2   <= $signed({h_c[HW-1], h_c}) - $signed({h_d[HW-1], h_d});
			dx_s2   <= $signed({h_c[HW-1], h_c}) - $signed({h_r[HW-1], h_r});
		end
	end

endmodule

[rtl/core/hfrs_color.sv]
`timescale 1ns / 1ps
module hfrs_color #(
	parameter int GRID_SHIFT   = hfrs_pkg::GRID_SHIFT_DEF,
	parameter int HEIGHT_WIDTH = hfrs_pkg::HEIGHT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid_s2,
	input  hfrs_pkg::item_t                     item_s2,
	input  logic signed [HEIGHT_WIDTH:0]        dx_s2,
	input  logic signed [HEIGHT_WIDTH:0]        dy_s2,
	input  hfrs_pkg::cfg_t                      cfg,
	output logic                                valid_s4,
	output logic [hfrs_pkg::POS_W-1:0]          pixel_x_s4,
	output logic [hfrs_pkg::POS_W-1:0]          pixel_y_s4,
	output logic [hfrs_pkg::TEXEL_W-1:0]        pixel_color_s4
);

	localparam int GW    = GRID_SHIFT;
	localparam int AW    = 2 * GW;
	localparam int DEPTH = 1 << AW;
	localparam int DW    = HEIGHT_WIDTH + 1;
	localparam int SW    = hfrs_pkg::SHADE_W;
	localparam int CW    = 18;
	localparam int TW    = hfrs_pkg::TEXEL_W;

	logic signed [DW-1:0] sh_full, sh_rm, off_x, off_y;
	logic signed [SW-1:0] shade_c, shade_s3;
	logic [GW-1:0]        tx, ty;
	logic [AW-1:0]        waddr, raddr;
	logic                 we;
	logic [TW-1:0]        texel_s3;
	logic                 valid_s3;
	hfrs_pkg::item_t      item_s3;
	logic signed [CW-1:0] shade_w, r, g, b;
	logic [TW-1:0]        color_c;

	always_comb begin
		sh_full = dy_s2 >>> cfg.shade_shift;
		if (sh_full == hfrs_pkg::SHADE_TRAP) begin
			sh_rm = DW'(hfrs_pkg::SHADE_SUB);
		end else begin
			sh_rm = sh_full;
		end
		if (sh_rm > hfrs_pkg::SHADE_SAT) begin
			shade_c = SW'(hfrs_pkg::SHADE_SAT);
		end else if (sh_rm < -hfrs_pkg::SHADE_SAT) begin
			shade_c = SW'(-hfrs_pkg::SHADE_SAT);
		end else begin
			shade_c = sh_rm[SW-1:0];
		end
		off_x = dx_s2 >>> cfg.refract_shift;
		off_y = dy_s2 >>> cfg.refract_shift;
		tx    = GW'(item_s2.pos_x) + off_x[GW-1:0] - GW'(cfg.wind_col);
		ty    = GW'(item_s2.pos_y) + off_y[GW-1:0] - GW'(cfg.wind_row);
		raddr = {ty, tx};
		waddr = {GW'(item_s2.pos_y), GW'(item_s2.pos_x)};
		we    = en && valid_s2 && (item_s2.action == hfrs_pkg::ACT_WRITE_TEXEL);
	end

	hfrs_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_ram_tex (
		.clk(clk), .we(we), .waddr(waddr), .wdata(item_s2.texel_value),
		.re(en), .raddr(raddr), .rdata(texel_s3)
	);

	always_comb begin
		shade_w = CW'(shade_s3);
		r = $signed(CW'(texel_s3 & hfrs_pkg::RED_MASK)) - (shade_w <<< hfrs_pkg::RED_POS);
		g = $signed(CW'(texel_s3 & hfrs_pkg::GRN_MASK)) - (shade_w <<< hfrs_pkg::GRN_POS);
		b = $signed(CW'(texel_s3 & hfrs_pkg::BLU_MASK)) - shade_w;
		if (r > hfrs_pkg::RED_MAX) begin
			r = CW'(hfrs_pkg::RED_MAX);
		end
		if (r < hfrs_pkg::RED_MIN) begin
			r = CW'(hfrs_pkg::RED_MIN);
		end
		if (g > hfrs_pkg::GRN_LIMIT) begin
			g = CW'(hfrs_pkg::GRN_MAX);
		end
		if (g < hfrs_pkg::GRN_MIN) begin
			g = CW'(hfrs_pkg::GRN_MIN);
		end
		if (b > hfrs_pkg::BLU_LIMIT) begin
			b = CW'(hfrs_pkg::BLU_MAX);
		end
		color_c = hfrs_pkg::ALPHA | r[TW-1:0] | g[TW-1:0];
		if (b >= 0) begin
			color_c = color_c | b[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 && (item_s3.action == hfrs_pkg::ACT_SHADE);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3        <= item_s2;
			shade_s3       <= shade_c;
			pixel_x_s4     <= hfrs_pkg::POS_W'(GW'(item_s3.pos_x));
			pixel_y_s4     <= hfrs_pkg::POS_W'(GW'(item_s3.pos_y));
			pixel_color_s4 <= color_c;
		end
	end

endmodule

[rtl/core/heightfield_refraction_shader.sv]
`timescale 1ns / 1ps
// Heightfield refraction shader: one item per clock on the input stream, a
// shaded pixel on m_tvalid for each shade item that is taken; height
// and texel writes use a slot each and emit nothing. The four-stage pipeline is
// set by the registered reads of the height grid (three copies, one per sampled
// cell) and of the source texture; the whole pipe stalls only while a
// finished pixel waits on m_tready. Writes and reads of each store keep stream
// order, so a shade item sees every write accepted before it. Stores come up
// unwritten, with no clearing pass: shade only pixels whose entries were loaded.
module heightfield_refraction_shader #(
	parameter int GRID_SHIFT   = hfrs_pkg::GRID_SHIFT_DEF,
	parameter int HEIGHT_WIDTH = hfrs_pkg::HEIGHT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pos_x, pos_y, height_value, texel_value, zero pad
	input  logic [47:0]                      s_tdata,
	// action
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// pixel_x, pixel_y, pixel_color, zero pad
	output logic [31:0]                      m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hfrs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hfrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	hfrs_pkg::cfg_t                      cfg;
	hfrs_pkg::item_t                     in_item, item_s2;
	logic                                advance, valid_s2, valid_s4;
	logic signed [HEIGHT_WIDTH:0]        dx_s2, dy_s2;
	logic [hfrs_pkg::POS_W-1:0]          pixel_x_s4, pixel_y_s4;
	logic [hfrs_pkg::TEXEL_W-1:0]        pixel_color_s4;

	assign advance  = !valid_s4 || m_tready;
	assign s_tready = advance;
	assign m_tvalid = valid_s4;
	assign m_tdata  = {6'd0, pixel_color_s4, pixel_y_s4, pixel_x_s4};

	always_comb begin
		in_item.action       = hfrs_pkg::action_t'(s_tuser);
		in_item.pos_x        = s_tdata[4:0];
		in_item.pos_y        = s_tdata[9:5];
		in_item.height_value = $signed(s_tdata[25:10]);
		in_item.texel_value  = s_tdata[41:26];
	end

	hfrs_cfg u_cfg (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.cfg(cfg)
	);

	hfrs_height #(.GRID_SHIFT(GRID_SHIFT), .HEIGHT_WIDTH(HEIGHT_WIDTH)) u_height (
		.clk(clk), .arst_n(arst_n), .en(advance),
		.in_valid(s_tvalid), .in_item(in_item), .cfg(cfg),
		.valid_s2(valid_s2), .item_s2(item_s2), .dx_s2(dx_s2), .dy_s2(dy_s2)
	);

	hfrs_color #(.GRID_SHIFT(GRID_SHIFT), .HEIGHT_WIDTH(HEIGHT_WIDTH)) u_color (
		.clk(clk), .arst_n(arst_n), .en(advance),
		.valid_s2(valid_s2), .item_s2(item_s2), .dx_s2(dx_s2), .dy_s2(dy_s2),
		.cfg(cfg),
		.valid_s4(valid_s4), .pixel_x_s4(pixel_x_s4), .pixel_y_s4(pixel_y_s4),
		.pixel_color_s4(pixel_color_s4)
	);

endmodule

[rtl/core/hfrs_checker.sv]
`timescale 1ns / 1ps
`include "heightfield_refraction_shader_macros.svh"
module hfrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	`HFRS_ASSERT_SAME(a_empty_takes_input, clk, arst_n, !m_tvalid, s_tready)
	`HFRS_ASSERT_SAME(a_drain_takes_input, clk, arst_n, m_tready, s_tready)
	`HFRS_ASSERT_SAME(a_block_on_stall, clk, arst_n, s_tvalid && !s_tready, m_tvalid && !m_tready)
	`HFRS_ASSERT_NEXT(a_stall_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind heightfield_refraction_shader hfrs_checker u_hfrs_checker (.*);

[sim/shade_checker.sv]
`timescale 1ns / 1ps
module shade_checker
	import hfrs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [47:0]            s_tdata,
	input  logic [1:0]             s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [31:0]            m_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending
);

	typedef struct packed {
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [TEXEL_W-1:0] color;
	} shaded_px_t;

	logic signed [SAMPLE_W-1:0] heights [1024];
	logic [TEXEL_W-1:0]         texels [1024];
	cfg_t                       live_cfg;
	shaded_px_t                 pixel_queue [$];
	int                         errs = 0;

	task automatic report(input string what);
		errs++;
		if (errs <= 100)
			$display("shade_checker: %0t ns: %s", $time, what);
	endtask

	function automatic shaded_px_t shade_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
		shaded_px_t         px;
		logic [POS_W-1:0]   gx, gy, gx1, gy1, tx, ty;
		int                 h0, h_down, h_right, dy, dx, shade, tsum_x, tsum_y, r, g, b;
		logic [TEXEL_W-1:0] c, col;
		gx = x + live_cfg.wind_col;
		gy = y + live_cfg.wind_row;
		gx1 = gx + 5'd1;
		gy1 = gy + 5'd1;
		h0 = heights[{gy, gx}];
		h_down = heights[{gy1, gx}];
		h_right = heights[{gy, gx1}];
		dy = h0 - h_down;
		dx = h0 - h_right;
		shade = dy >>> live_cfg.shade_shift;
		if (shade == SHADE_TRAP)
			shade = SHADE_SUB;
		tsum_x = int'(x) + (dx >>> live_cfg.refract_shift) - int'(live_cfg.wind_col);
		tsum_y = int'(y) + (dy >>> live_cfg.refract_shift) - int'(live_cfg.wind_row);
		tx = tsum_x[POS_W-1:0];
		ty = tsum_y[POS_W-1:0];
		c = texels[{ty, tx}];
		r = int'(c & RED_MASK) - shade * (1 << RED_POS);
		g = int'(c & GRN_MASK) - shade * (1 << GRN_POS);
		b = int'(c & BLU_MASK) - shade;
		if (r > RED_MAX) r = RED_MAX;
		if (r < RED_MIN) r = RED_MIN;
		if (g > GRN_LIMIT) g = GRN_MAX;
		if (g < GRN_MIN) g = GRN_MIN;
		if (b > BLU_LIMIT) b = BLU_MAX;
		col = ALPHA | 16'(r) | 16'(g);
		if (b >= 0)
			col = col | 16'(b);
		px.x = x;
		px.y = y;
		px.color = col;
		return px;
	endfunction

	always @(posedge clk) begin : watch
		shaded_px_t want;
		if (!arst_n) begin
			live_cfg.shade_shift = SHADE_SHIFT_RST;
			live_cfg.refract_shift = REFRACT_SHIFT_RST;
			live_cfg.wind_col = WIND_RST;
			live_cfg.wind_row = WIND_RST;
			pixel_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SHADE_SHIFT:   live_cfg.shade_shift = cfg_data[SHIFT_W-1:0];
					REG_REFRACT_SHIFT: live_cfg.refract_shift = cfg_data[SHIFT_W-1:0];
					REG_WIND_COL:      live_cfg.wind_col = cfg_data[WIND_W-1:0];
					REG_WIND_ROW:      live_cfg.wind_row = cfg_data[WIND_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (pixel_queue.size() == 0) begin
					report($sformatf("unexpected pixel beat %h", m_tdata));
				end else begin
					want = pixel_queue.pop_front();
					if (m_tdata[4:0] !== want.x)
						report($sformatf("pixel_x got %h want %h", m_tdata[4:0], want.x));
					if (m_tdata[9:5] !== want.y)
						report($sformatf("pixel_y got %h want %h", m_tdata[9:5], want.y));
					if (m_tdata[25:10] !== want.color)
						report($sformatf("pixel_color got %h want %h at (%0d,%0d)",
							m_tdata[25:10], want.color, want.x, want.y));
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					ACT_WRITE_HEIGHT: heights[s_tdata[9:0]] = s_tdata[25:10];
					ACT_WRITE_TEXEL:  texels[s_tdata[9:0]] = s_tdata[41:26];
					ACT_SHADE:        pixel_queue.push_back(shade_pixel(s_tdata[4:0], s_tdata[9:5]));
					default: ;
				endcase
			end
		end
		fail_count <= errs;
		pending <= pixel_queue.size();
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import hfrs_pkg::*;

	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam int         IDLE_LIMIT  = 2000;
	localparam int         PHASES      = 7;
	localparam int         PHASE_ITEMS = 60;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// pos_x, pos_y, height_value, texel_value, zero pad
	logic [47:0]            s_tdata;
	// action
	logic [1:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// pixel_x, pixel_y, pixel_color, zero pad
	logic [31:0]            m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     fail_count;
	int                     pending;
	int                     calm_left = 0;

	heightfield_refraction_shader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	shade_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2)
			calm_left = $urandom_range(20, 80);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_height();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return SAMPLE_W'($urandom_range(0, 80) - 40);
		if (roll < 8)
			return SAMPLE_W'($urandom);
		if (roll == 8)
			return 16'h7FFF;
		return 16'h8000;
	endfunction

	task automatic send_beat(input logic [1:0] act, input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y, input logic [SAMPLE_W-1:0] h, input logic [TEXEL_W-1:0] tex);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {6'd0, tex, h, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_regs(input int sh, input int rf, input int wc, input int wr);
		logic [CFG_INDEX_W-1:0] idx [4];
		int                     vals [4];
		idx = '{REG_SHADE_SHIFT, REG_REFRACT_SHIFT, REG_WIND_COL, REG_WIND_ROW};
		vals = '{sh, rf, wc, wr};
		cfg_valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= idx[i];
			cfg_data <= vals[i][CFG_DATA_W-1:0];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(output bit counted);
		int         roll;
		logic [1:0] act;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			act = ACT_SHADE;
		else if (roll < 70)
			act = ACT_WRITE_HEIGHT;
		else if (roll < 90)
			act = ACT_WRITE_TEXEL;
		else
			act = ACT_UNUSED;
		send_beat(act, POS_W'($urandom_range(0, 31)), POS_W'($urandom_range(0, 31)),
			pick_height(), TEXEL_W'($urandom));
		counted = (act != ACT_UNUSED);
	endtask

	// shade 6 remap, both clamp extremes, wrap at the far corner, ignored action
	task automatic run_directed();
		send_beat(ACT_WRITE_HEIGHT, 5'd0, 5'd0, 16'd24, TEXEL_W'($urandom));
		send_beat(ACT_WRITE_HEIGHT, 5'd0, 5'd1, 16'd0, TEXEL_W'($urandom));
		send_beat(ACT_WRITE_HEIGHT, 5'd1, 5'd0, 16'd24, TEXEL_W'($urandom));
		send_beat(ACT_WRITE_TEXEL, 5'd0, 5'd3, SAMPLE_W'($urandom), 16'hFFFF);
		send_beat(ACT_SHADE, 5'd0, 5'd0, SAMPLE_W'($urandom), TEXEL_W'($urandom));
		send_beat(ACT_WRITE_TEXEL, 5'd0, 5'd3, SAMPLE_W'($urandom), 16'h0000);
		send_beat(ACT_SHADE, 5'd0, 5'd0, SAMPLE_W'($urandom), TEXEL_W'($urandom));
		send_beat(ACT_WRITE_HEIGHT, 5'd5, 5'd5, 16'h8000, TEXEL_W'($urandom));
		send_beat(ACT_WRITE_HEIGHT, 5'd5, 5'd6, 16'h7FFF, TEXEL_W'($urandom));
		send_beat(ACT_WRITE_HEIGHT, 5'd6, 5'd5, 16'h7FFF, TEXEL_W'($urandom));
		send_beat(ACT_SHADE, 5'd5, 5'd5, SAMPLE_W'($urandom), TEXEL_W'($urandom));
		send_beat(ACT_WRITE_HEIGHT, 5'd9, 5'd9, 16'h7FFF, TEXEL_W'($urandom));
		send_beat(ACT_WRITE_HEIGHT, 5'd9, 5'd10, 16'h8000, TEXEL_W'($urandom));
		send_beat(ACT_WRITE_HEIGHT, 5'd10, 5'd9, 16'h8000, TEXEL_W'($urandom));
		send_beat(ACT_SHADE, 5'd9, 5'd9, SAMPLE_W'($urandom), TEXEL_W'($urandom));
		send_beat(ACT_WRITE_TEXEL, 5'd31, 5'd31, SAMPLE_W'($urandom), 16'hFFFF);
		send_beat(ACT_WRITE_HEIGHT, 5'd31, 5'd31, 16'h7FFF, TEXEL_W'($urandom));
		send_beat(ACT_SHADE, 5'd31, 5'd31, SAMPLE_W'($urandom), TEXEL_W'($urandom));
		send_beat(ACT_UNUSED, POS_W'($urandom), POS_W'($urandom), SAMPLE_W'($urandom),
			TEXEL_W'($urandom));
		send_beat(ACT_SHADE, 5'd31, 5'd0, SAMPLE_W'($urandom), TEXEL_W'($urandom));
	endtask

	initial begin : sink_pace
		int run;
		m_tready <= 1'b1;
		forever begin
			if ($urandom_range(0, 9) == 0)
				run = $urandom_range(50, 200);
			else
				run = $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			run = $urandom_range(0, 99);
			if (run < 85)
				run = $urandom_range(1, 3);
			else if (run < 97)
				run = $urandom_range(4, 12);
			else
				run = $urandom_range(20, 40);
			m_tready <= 1'b0;
			repeat (run) @(posedge clk);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : stimulus
		int count;
		bit counted;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= '0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both stores so that every later read hits a written entry
		for (int y = 0; y < 32; y++) begin
			for (int x = 0; x < 32; x++) begin
				send_beat(ACT_WRITE_HEIGHT, POS_W'(x), POS_W'(y), pick_height(),
					TEXEL_W'($urandom));
				send_beat(ACT_WRITE_TEXEL, POS_W'(x), POS_W'(y), SAMPLE_W'($urandom),
					TEXEL_W'($urandom));
			end
		end

		run_directed();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain_results();
				repeat (8) @(posedge clk);
				case (phase)
					1: write_regs(0, 0, 0, 0);
					2: write_regs(15, 15, 31, 31);
					3: write_regs($urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 31), $urandom_range(0, 31));
					4: write_regs(0, 15, 31, 0);
					5: write_regs(15, 0, 0, 31);
					default: write_regs($urandom_range(0, 4), $urandom_range(0, 6),
						$urandom_range(0, 31), $urandom_range(0, 31));
				endcase
			end
			count = 0;
			while (count < PHASE_ITEMS) begin
				random_item(counted);
				if (counted)
					count++;
				if ($urandom_range(0, 149) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
